### sv/gc3s_pkg.sv
// gc3s_pkg.sv: constants, codes and shared types for the 3x3 grayscale convolution stream.
// No dependencies; imported by every module of the block.
package gc3s_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int KERNEL_DIM = 3;
  localparam int TAPS       = KERNEL_DIM * KERNEL_DIM;
  localparam int CENTER     = TAPS / 2;

  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WEFF_W     = ADDR_W + 1;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int POS_W      = ADDR_W + HEIGHT_W;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int COEF_ROW_W = KERNEL_DIM * COEF_W;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int PART_W     = PROD_W + 2;
  localparam int SUM_W      = PROD_W + 4;
  localparam int FRAC_W     = 8;
  localparam int Q_W        = SUM_W - 1 - FRAC_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_ROW_W;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_AW + 1;
  // edges from request acceptance to the result sitting in the output queue
  localparam int PIPE_DEPTH = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd5;

  localparam logic FUNC_PIXEL = 1'b0;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef pix_t [TAPS-1:0]   window_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [TAPS-1:0]  kernel_t;

  // one request as seen by the line memory
  typedef struct packed {
    logic              valid;
    logic              is_pix;
    logic              emit;
    logic              interior;
    logic              lastrow;
    logic              last;
    logic [ADDR_W-1:0] addr;
    pix_t              pix;
  } lb_req_t;

  // per-result control travelling alongside the arithmetic
  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
    pix_t border;
  } flt_meta_t;

endpackage

### sv/gray_conv3x3_stream_top.sv
// Streaming 3x3 convolution on 8-bit grayscale pixels, one request per clock sustained
// while in_stall is low. Results trail the input by an image lag of one row plus one
// pixel. Admission is set by the 16-entry output queue. A width or height write holds
// in_stall while the divider rebuilds row/column positions. Synchronous reset clears
// config, counters, window and queue; the line memory is not cleared.
module gray_conv3x3_stream_top
  import gc3s_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [PIX_W-1:0]      pixel_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      pixel_out,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WEFF_W-1:0]     w_eff;
  logic [HEIGHT_W-1:0]   h_eff;
  logic                  abs_mode;
  logic [COEF_ROW_W-1:0] coef_top;
  logic [COEF_ROW_W-1:0] coef_mid;
  logic [COEF_ROW_W-1:0] coef_bot;
  logic [POS_W-1:0]      total;
  logic [POS_W-1:0]      v_pos;
  logic [POS_W-1:0]      o_pos;
  logic [ADDR_W-1:0]     in_col;
  logic [ADDR_W-1:0]     out_col;
  logic [HEIGHT_W-1:0]   out_row;
  logic                  sync_req;

  logic                  cfg_wr;
  logic [WEFF_W-1:0]     w_cfg;
  logic [HEIGHT_W-1:0]   h_cfg;
  logic [WIDTH_W-1:0]    w_raw;
  logic [HEIGHT_W-1:0]   h_raw;

  logic                  div_busy;
  logic                  div_done;
  logic [WEFF_W-1:0]     rem_a;
  logic [POS_W-1:0]      quo_b;
  logic [WEFF_W-1:0]     rem_b;
  logic                  resync_busy;

  logic                  acc;
  logic                  is_pix;
  logic                  pix_emit;
  logic                  flush_emit;
  logic                  emit;
  logic                  o_last;
  logic                  in_col_wrap;
  logic                  out_col_wrap;
  logic                  interior;
  logic                  lastrow;

  lb_req_t               req;
  window_t               win;
  flt_meta_t             meta;
  kernel_t               kern;
  logic                  res_valid;
  pix_t                  res_pixel;
  logic                  res_last;
  logic [FIFO_CNT_W-1:0] fifo_count;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign w_raw     = cfg_data[WIDTH_W-1:0];
  assign h_raw     = cfg_data[HEIGHT_W-1:0];

  always_comb begin
    if (w_raw == '0) begin
      w_cfg = WEFF_W'(1);
    end else if (32'(w_raw) > MAX_WIDTH) begin
      w_cfg = WEFF_W'(MAX_WIDTH);
    end else begin
      w_cfg = WEFF_W'(w_raw);
    end
    h_cfg = (h_raw == '0) ? HEIGHT_W'(1) : h_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff    <= WEFF_W'(1);
      h_eff    <= HEIGHT_W'(1);
      abs_mode <= 1'b0;
      coef_top <= '0;
      coef_mid <= '0;
      coef_bot <= '0;
      total    <= POS_W'(1);
      sync_req <= 1'b0;
    end else begin
      total    <= POS_W'(w_eff * h_eff);
      sync_req <= cfg_wr && ((cfg_index == REG_IMAGE_WIDTH) ||
                             (cfg_index == REG_IMAGE_HEIGHT));
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  w_eff    <= w_cfg;
          REG_IMAGE_HEIGHT: h_eff    <= h_cfg;
          REG_ABS_MODE:     abs_mode <= cfg_data[0];
          REG_COEF_TOP:     coef_top <= cfg_data;
          REG_COEF_MID:     coef_mid <= cfg_data;
          REG_COEF_BOTTOM:  coef_bot <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign kern = {coef_bot, coef_mid, coef_top};

  gc3s_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (sync_req),
    .dividend_a (v_pos),
    .dividend_b (o_pos),
    .divisor    (w_eff),
    .busy       (div_busy),
    .done       (div_done),
    .rem_a      (rem_a),
    .quo_b      (quo_b),
    .rem_b      (rem_b)
  );

  assign resync_busy = sync_req || div_busy || div_done;
  assign in_stall    = resync_busy ||
                       (fifo_count >= FIFO_CNT_W'(FIFO_DEPTH - PIPE_DEPTH));
  assign acc         = in_valid && !in_stall;

  // a pixel past the end of the image counts as a flush request
  assign is_pix       = (func == FUNC_PIXEL) && (v_pos < total);
  assign pix_emit     = is_pix && (v_pos > POS_W'(w_eff));
  assign flush_emit   = !is_pix && (v_pos >= total);
  assign emit         = pix_emit || flush_emit;
  assign o_last       = (o_pos + POS_W'(1)) == total;
  assign in_col_wrap  = (WEFF_W'(in_col) + WEFF_W'(1)) == w_eff;
  assign out_col_wrap = (WEFF_W'(out_col) + WEFF_W'(1)) == w_eff;
  assign interior     = (out_row != '0) && (out_col != '0) &&
                        ((HEIGHT_W+1)'(out_row) + (HEIGHT_W+1)'(2) <= (HEIGHT_W+1)'(h_eff)) &&
                        (WEFF_W'(out_col) + WEFF_W'(2) <= w_eff);
  assign lastrow      = ((HEIGHT_W+1)'(out_row) + (HEIGHT_W+1)'(1)) == (HEIGHT_W+1)'(h_eff);

  always_comb begin
    req.valid    = acc && (is_pix || emit);
    req.is_pix   = is_pix;
    req.emit     = emit;
    req.interior = interior;
    req.lastrow  = lastrow;
    req.last     = o_last;
    req.addr     = is_pix ? in_col : out_col;
    req.pix      = pixel_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pos   <= '0;
      o_pos   <= '0;
      in_col  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (div_done) begin
      if (o_pos >= total) begin
        v_pos   <= '0;
        o_pos   <= '0;
        in_col  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col  <= rem_a[ADDR_W-1:0];
        out_col <= rem_b[ADDR_W-1:0];
        out_row <= quo_b[HEIGHT_W-1:0];
      end
    end else if (acc) begin
      if (emit && o_last) begin
        v_pos   <= '0;
        o_pos   <= '0;
        in_col  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (is_pix) begin
          v_pos  <= v_pos + 1'b1;
          in_col <= in_col_wrap ? '0 : in_col + 1'b1;
        end
        if (emit) begin
          o_pos <= o_pos + 1'b1;
          if (out_col_wrap) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  gc3s_line_buf u_line_buf (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .win  (win),
    .meta (meta)
  );

  gc3s_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .meta_in   (meta),
    .kern      (kern),
    .abs_mode  (abs_mode),
    .res_valid (res_valid),
    .res_pixel (res_pixel),
    .res_last  (res_last)
  );

  gc3s_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_pixel (res_pixel),
    .push_last  (res_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .last       (last),
    .count      (fifo_count)
  );

  a_out_pos_in_image: assert property (@(posedge clk) disable iff (rst)
    !resync_busy |-> (o_pos < total))
    else $error("output position beyond image");

  a_in_col_in_row: assert property (@(posedge clk) disable iff (rst)
    !resync_busy |-> (WEFF_W'(in_col) < w_eff))
    else $error("input column beyond row width");

endmodule

### sv/gc3s_div.sv
// gc3s_div.sv: bit-serial restoring divider, two dividends over one divisor.
// Recovers column and row positions after a geometry change. Uses gc3s_pkg.
module gc3s_div
  import gc3s_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [POS_W-1:0]  dividend_a,
  input  logic [POS_W-1:0]  dividend_b,
  input  logic [WEFF_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [WEFF_W-1:0] rem_a,
  output logic [POS_W-1:0]  quo_b,
  output logic [WEFF_W-1:0] rem_b
);

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [POS_W-1:0]  a_sh;
  logic [POS_W-1:0]  b_sh;
  logic [WEFF_W-1:0] dv;
  logic [WEFF_W-1:0] ra;
  logic [WEFF_W-1:0] rb;
  logic [CNT_W-1:0]  cnt;
  logic [WEFF_W:0]   sa;
  logic [WEFF_W:0]   sb;
  logic              ga;
  logic              gb;

  assign sa = {ra, a_sh[POS_W-1]};
  assign sb = {rb, b_sh[POS_W-1]};
  assign ga = sa >= {1'b0, dv};
  assign gb = sb >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(POS_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= dividend_a;
      b_sh <= dividend_b;
      dv   <= divisor;
      ra   <= '0;
      rb   <= '0;
    end else if (busy) begin
      ra   <= ga ? WEFF_W'(sa - {1'b0, dv}) : WEFF_W'(sa);
      rb   <= gb ? WEFF_W'(sb - {1'b0, dv}) : WEFF_W'(sb);
      a_sh <= {a_sh[POS_W-2:0], 1'b0};
      // quotient bits shift in behind the dividend
      b_sh <= {b_sh[POS_W-2:0], gb};
    end
  end

  assign rem_a = ra;
  assign quo_b = b_sh;
  assign rem_b = rb;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (ra < dv) && (rb < dv))
    else $error("divider remainder not below divisor");

endmodule

### sv/gc3s_line_buf.sv
// gc3s_line_buf.sv: line memory holding the two previous rows, with write forwarding,
// and the 3x3 pixel window. Uses gc3s_pkg.
module gc3s_line_buf
  import gc3s_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lb_req_t   req,
  output window_t   win,
  output flt_meta_t meta
);

  typedef logic [2*PIX_W-1:0] entry_t;

  // each entry: upper row in the high byte, lower row in the low byte
  entry_t  mem [MAX_WIDTH];
  entry_t  rd_q;
  entry_t  fwd_data;
  entry_t  ent;
  logic    fwd;
  lb_req_t s1;
  pix_t    up;
  pix_t    lo;

  assign ent = fwd ? fwd_data : rd_q;
  assign up  = ent[2*PIX_W-1:PIX_W];
  assign lo  = ent[PIX_W-1:0];

  always_ff @(posedge clk) begin
    rd_q <= mem[req.addr];
    if (s1.valid && s1.is_pix) begin
      mem[s1.addr] <= {lo, s1.pix};
    end
    fwd_data <= {lo, s1.pix};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= '0;
      fwd  <= 1'b0;
      win  <= '0;
      meta <= '0;
    end else begin
      s1 <= req;
      // the read just issued misses the write landing on this same edge
      fwd <= req.valid && s1.valid && s1.is_pix && (req.addr == s1.addr);
      meta.valid    <= s1.valid && s1.emit;
      meta.interior <= s1.interior && s1.is_pix;
      meta.last     <= s1.last;
      meta.border   <= s1.is_pix ? win[CENTER+1] : (s1.lastrow ? lo : up);
      if (s1.valid && s1.is_pix) begin
        for (int r = 0; r < KERNEL_DIM; r++) begin
          for (int c = 0; c < KERNEL_DIM - 1; c++) begin
            win[r*KERNEL_DIM+c] <= win[r*KERNEL_DIM+c+1];
          end
        end
        win[KERNEL_DIM-1]   <= up;
        win[2*KERNEL_DIM-1] <= lo;
        win[TAPS-1]         <= s1.pix;
      end
    end
  end

endmodule

### sv/gc3s_filter.sv
// gc3s_filter.sv: pipelined 3x3 multiply-accumulate, magnitude, round-half-even and clamp.
// Five register stages; border pixels ride along unchanged. Uses gc3s_pkg.
module gc3s_filter
  import gc3s_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  window_t   win,
  input  flt_meta_t meta_in,
  input  kernel_t   kern,
  input  logic      abs_mode,
  output logic      res_valid,
  output pix_t      res_pixel,
  output logic      res_last
);

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PART_W-1:0] part_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam logic [FRAC_W-1:0] HALF    = FRAC_W'(1) << (FRAC_W - 1);
  localparam logic [Q_W:0]      PIX_MAX = (Q_W+1)'((1 << PIX_W) - 1);

  prod_t     prod [TAPS];
  part_t     part [KERNEL_DIM];
  sum_t      sum;
  sum_t      mag;
  logic      mag_pos;
  logic      sum_pos;
  flt_meta_t m1;
  flt_meta_t m2;
  flt_meta_t m3;
  flt_meta_t m4;

  logic [Q_W-1:0]    q;
  logic [FRAC_W-1:0] frac;
  logic              inc;
  logic [Q_W:0]      qr;
  pix_t              filt;

  always_comb begin
    if (abs_mode) begin
      sum_pos = (sum != '0);
    end else begin
      sum_pos = !sum[SUM_W-1] && (sum != '0);
    end
  end

  assign q    = mag[SUM_W-2:FRAC_W];
  assign frac = mag[FRAC_W-1:0];
  assign inc  = (frac > HALF) || ((frac == HALF) && q[0]);
  assign qr   = (Q_W+1)'(q) + (Q_W+1)'(inc);
  assign filt = (qr > PIX_MAX) ? pix_t'(PIX_MAX) : qr[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1        <= '0;
      m2        <= '0;
      m3        <= '0;
      m4        <= '0;
      res_valid <= 1'b0;
    end else begin
      m1        <= meta_in;
      m2        <= m1;
      m3        <= m2;
      m4        <= m3;
      res_valid <= m4.valid;
    end
  end

  always_ff @(posedge clk) begin
    // true convolution: the kernel is applied flipped
    for (int i = 0; i < TAPS; i++) begin
      prod[i] <= $signed({1'b0, win[i]}) * $signed(kern[TAPS-1-i]);
    end
    for (int r = 0; r < KERNEL_DIM; r++) begin
      part[r] <= PART_W'(prod[r*KERNEL_DIM]) + PART_W'(prod[r*KERNEL_DIM+1])
               + PART_W'(prod[r*KERNEL_DIM+2]);
    end
    sum     <= SUM_W'(part[0]) + SUM_W'(part[1]) + SUM_W'(part[2]);
    mag     <= (abs_mode && sum[SUM_W-1]) ? -sum : sum;
    mag_pos <= sum_pos;
    if (!m4.interior) begin
      res_pixel <= m4.border;
    end else if (!mag_pos) begin
      res_pixel <= '0;
    end else begin
      res_pixel <= filt;
    end
    res_last <= m4.last;
  end

endmodule

### sv/gc3s_out_fifo.sv
// gc3s_out_fifo.sv: result queue between the pipeline and the output channel.
// Occupancy goes back to the top level for request admission. Uses gc3s_pkg.
module gc3s_out_fifo
  import gc3s_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pix_t                  push_pixel,
  input  logic                  push_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_t                  pixel_out,
  output logic                  last,
  output logic [FIFO_CNT_W-1:0] count
);

  typedef struct packed {
    logic last;
    pix_t pixel;
  } fifo_ent_t;

  fifo_ent_t          store [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign pixel_out = store[rd_ptr].pixel;
  assign last      = store[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= {push_last, push_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count != FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("output queue overflow");

endmodule

### sim/tb_gray_conv3x3_stream_top.sv
// Self-checking testbench for gray_conv3x3_stream_top: directed script, extreme geometries,
// then random images checked against an in-bench predictor of the 3x3 filter.
// Depends on gc3s_pkg (sv/gc3s_pkg.sv) and the block's RTL.
`timescale 1ns / 100ps

module tb_gray_conv3x3_stream_top;
  import gc3s_pkg::*;

  localparam logic                 FUNC_FLUSH = ~FUNC_PIXEL;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
  localparam int RAND_ITEMS = 1900;
  localparam int SETTLE_CYC = PIPE_DEPTH * 3;
  localparam int DRAIN_CYC  = PIPE_DEPTH * 4;
  localparam int HANG_LIMIT = 5000;

  typedef struct packed {
    pix_t pix;
    logic last;
  } px_res_t;

  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  op;
    pix_t                  pix;
    logic                  chk;
    pix_t                  xpix;
    logic                  xlast;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  func;
  logic [PIX_W-1:0]      pixel_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      pixel_out;
  logic                  last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // typed expectation travelling with the request being driven
  logic row_chk;
  pix_t row_pix;
  logic row_last;
  logic calm;

  gray_conv3x3_stream_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- filter predictor ----------------
  logic [WIDTH_W-1:0]    m_width;
  logic [HEIGHT_W-1:0]   m_height;
  logic                  m_abs;
  logic [COEF_ROW_W-1:0] m_krow [KERNEL_DIM];
  pix_t                  ls_upper [MAX_WIDTH];
  pix_t                  ls_lower [MAX_WIDTH];
  pix_t                  win [TAPS];
  int unsigned           in_pos;
  int unsigned           out_pos;

  px_res_t pending_px [$];

  int n_req, n_res, n_img, n_regw, n_feed, n_miss;

  function automatic int unsigned eff_w();
    if (m_width == 0) return 1;
    if (m_width > MAX_WIDTH) return MAX_WIDTH;
    return m_width;
  endfunction

  function automatic int unsigned eff_h();
    return (m_height == 0) ? 1 : m_height;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_IMAGE_WIDTH:  m_width  = d[WIDTH_W-1:0];
      REG_IMAGE_HEIGHT: m_height = d[HEIGHT_W-1:0];
      REG_ABS_MODE:     m_abs    = d[0];
      REG_COEF_TOP:     m_krow[0] = d[COEF_ROW_W-1:0];
      REG_COEF_MID:     m_krow[1] = d[COEF_ROW_W-1:0];
      REG_COEF_BOTTOM:  m_krow[2] = d[COEF_ROW_W-1:0];
      default: ;
    endcase
  endfunction

  // flipped kernel: window tap i meets coefficient 8-i
  function automatic pix_t conv_window();
    longint            acc;
    longint unsigned   mag, q;
    logic signed [15:0] k;
    int                t;
    acc = 0;
    for (int i = 0; i < TAPS; i++) begin
      t = TAPS - 1 - i;
      k = m_krow[t / 3][16 * (t % 3) +: 16];
      acc += longint'(win[i]) * longint'(k);
    end
    if (m_abs && acc < 0) acc = -acc;
    if (acc <= 0) return '0;
    mag = acc;
    q   = mag >> 8;
    if (mag[7:0] > 8'd128 || (mag[7:0] == 8'd128 && q[0])) q++;
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  function automatic logic conv_step(input logic op, input pix_t p, output px_res_t res);
    int unsigned w, h, total, v, col, r, c;
    logic hit;
    w = eff_w();
    h = eff_h();
    total = w * h;
    hit = 1'b0;
    res = '0;
    if (out_pos >= total) begin
      in_pos  = 0;
      out_pos = 0;
    end
    if (op == FUNC_PIXEL && in_pos < total) begin
      v   = in_pos;
      col = v % w;
      for (int row = 0; row < KERNEL_DIM; row++) begin
        win[row*3]     = win[row*3 + 1];
        win[row*3 + 1] = win[row*3 + 2];
      end
      win[2] = ls_upper[col];
      win[5] = ls_lower[col];
      win[8] = p;
      ls_upper[col] = ls_lower[col];
      ls_lower[col] = p;
      in_pos = v + 1;
      if (v >= w + 1) begin
        r = out_pos / w;
        c = out_pos % w;
        if (r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w) res.pix = conv_window();
        else res.pix = win[CENTER];
        hit = 1'b1;
      end
    end else if (in_pos >= total) begin
      // tail drain: remaining outputs are border pixels still in the line stores
      r = out_pos / w;
      c = out_pos % w;
      res.pix = (r + 1 == h) ? ls_lower[c] : ls_upper[c];
      hit = 1'b1;
    end
    if (hit) begin
      res.last = (out_pos + 1 == total);
      out_pos++;
      if (out_pos >= total) begin
        in_pos  = 0;
        out_pos = 0;
      end
    end
    return hit;
  endfunction

  initial begin
    m_width  = 1;
    m_height = 1;
    m_abs    = 1'b0;
    for (int i = 0; i < KERNEL_DIM; i++) m_krow[i] = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      ls_upper[i] = '0;
      ls_lower[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) win[i] = '0;
    in_pos  = 0;
    out_pos = 0;
  end

  // ---------------- monitor and checker ----------------
  always @(posedge clk) begin : mon
    px_res_t pred;
    px_res_t want;
    logic    got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        n_regw++;
      end
      if (in_valid && !in_stall) begin
        n_req++;
        got = conv_step(func, pixel_in, pred);
        if (row_chk) pending_px.push_back({row_pix, row_last});
        else if (got) pending_px.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        n_res++;
        if (pending_px.size() == 0) begin
          n_miss++;
          if (n_miss <= 10)
            $display("[%0t] unexpected result: pixel %02h last %0b", $time, pixel_out, last);
        end else begin
          want = pending_px.pop_front();
          if (want.pix !== pixel_out || want.last !== last) begin
            n_miss++;
            if (n_miss <= 10)
              $display("[%0t] mismatch: expected pixel %02h last %0b, got pixel %02h last %0b",
                       $time, want.pix, want.last, pixel_out, last);
          end
        end
      end
    end
  end

  // no handshake of any kind for too long means the block has hung
  always @(posedge clk) begin : hang_watch
    int quiet;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= HANG_LIMIT) begin
      $display("[%0t] no progress for %0d cycles, %0d results outstanding",
               $time, HANG_LIMIT, pending_px.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);

  // ---------------- stimulus ----------------
  function automatic logic [CFG_DATA_W-1:0] junk48();
    logic [63:0] j;
    j = {$urandom, $urandom};
    return j[CFG_DATA_W-1:0];
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return coef_t'($urandom);
      default: return coef_t'($urandom_range(160)) - 16'd80;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_reg(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] d;
    // bits above a narrow field are sometimes left as noise
    d = ($urandom_range(3) == 0) ? junk48() : '0;
    case (idx)
      REG_IMAGE_WIDTH:
        d[WIDTH_W-1:0] = ($urandom_range(19) == 0) ? 0 :
                         ($urandom_range(4) == 0) ? $urandom_range(40, 1) : $urandom_range(10, 1);
      REG_IMAGE_HEIGHT:
        d[HEIGHT_W-1:0] = ($urandom_range(19) == 0) ? 0 :
                          ($urandom_range(4) == 0) ? $urandom_range(20, 1) : $urandom_range(8, 1);
      REG_ABS_MODE:
        d[0] = $urandom_range(1);
      default:
        d = {rand_coef(), rand_coef(), rand_coef()};
    endcase
    return d;
  endfunction

  function automatic step_row_t mk_req(input logic op, input pix_t p, input logic chk,
                                       input pix_t xp, input logic xl);
    step_row_t s;
    s = '0;
    s.op = op; s.pix = p; s.chk = chk; s.xpix = xp; s.xlast = xl;
    return s;
  endfunction

  function automatic step_row_t mk_reg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] d);
    step_row_t s;
    s = '0;
    s.is_reg = 1'b1; s.idx = idx; s.data = d;
    return s;
  endfunction

  // entered and left at a falling edge; valid stays up if the next request follows at once
  task automatic send_px(input logic op, input pix_t p, input logic chk,
                         input pix_t xp, input logic xl);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    pixel_in <= p;
    row_chk  <= chk;
    row_pix  <= xp;
    row_last <= xl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    // early flushes leave no result behind, so give the pipe time to empty
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one image to completion; break_at >= 0 rewrites a register mid-image
  task automatic run_image(input int break_at);
    int          sent, style;
    int unsigned tot;
    pix_t        base, p;
    logic [CFG_IDX_W-1:0] k;
    sent  = 0;
    style = $urandom_range(3);
    base  = $urandom;
    do begin
      if (sent == break_at) begin
        k = $urandom_range(5);
        write_reg(k, draw_reg(k));
      end
      tot = eff_w() * eff_h();
      case (style)
        0: p = base + pix_t'($urandom_range(16)) - 8'd8;
        1: p = $urandom_range(1) ? 8'hFF : 8'h00;
        default: p = $urandom;
      endcase
      if (in_pos < tot && $urandom_range(99) < 3) begin
        send_px(FUNC_FLUSH, p, 1'b0, '0, 1'b0);
      end else begin
        if (in_pos < tot || $urandom_range(3) == 0) send_px(FUNC_PIXEL, p, 1'b0, '0, 1'b0);
        else send_px(FUNC_FLUSH, p, 1'b0, '0, 1'b0);
        n_feed++;
      end
      sent++;
    end while (in_pos != 0 || out_pos != 0);
    n_img++;
  endtask

  initial begin : stim
    step_row_t script [$];
    int        feed_mark;
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = FUNC_PIXEL;
    pixel_in  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    row_chk   = 1'b0;
    row_pix   = '0;
    row_last  = 1'b0;
    calm      = 1'b0;
    n_req = 0; n_res = 0; n_img = 0; n_regw = 0; n_feed = 0; n_miss = 0;

    // 1x1 image from reset
    script.push_back(mk_req(FUNC_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0));
    script.push_back(mk_req(FUNC_FLUSH, 8'h5A, 1'b1, 8'h00, 1'b1));
    script.push_back(mk_req(FUNC_FLUSH, 8'h00, 1'b0, 8'h00, 1'b0));  // empty image: ignored
    script.push_back(mk_req(FUNC_PIXEL, 8'hFF, 1'b0, 8'h00, 1'b0));
    script.push_back(mk_req(FUNC_PIXEL, 8'hA5, 1'b1, 8'hFF, 1'b1));  // surplus pixel drains
    // 3x3, identity kernel in absolute mode
    script.push_back(mk_reg(REG_IMAGE_WIDTH, 48'd3));
    script.push_back(mk_reg(REG_IMAGE_HEIGHT, 48'd3));
    script.push_back(mk_reg(REG_ABS_MODE, 48'd1));
    script.push_back(mk_reg(REG_COEF_TOP, 48'h0));
    script.push_back(mk_reg(REG_COEF_MID, 48'h0000_0100_0000));
    script.push_back(mk_reg(REG_COEF_BOTTOM, 48'h0));
    script.push_back(mk_reg(REG_SPARE, 48'hFFFF_FFFF_FFFF));
    script.push_back(mk_req(FUNC_PIXEL, 8'h00, 1'b0, 8'h00, 1'b0));
    script.push_back(mk_req(FUNC_PIXEL, 8'hFF, 1'b0, 8'h00, 1'b0));
    script.push_back(mk_req(FUNC_PIXEL, 8'h12, 1'b0, 8'h00, 1'b0));
    script.push_back(mk_req(FUNC_PIXEL, 8'h34, 1'b0, 8'h00, 1'b0));
    script.push_back(mk_req(FUNC_FLUSH, 8'h77, 1'b0, 8'h00, 1'b0));  // too early
    script.push_back(mk_req(FUNC_PIXEL, 8'h33, 1'b1, 8'h00, 1'b0));
    script.push_back(mk_req(FUNC_PIXEL, 8'h78, 1'b1, 8'hFF, 1'b0));
    script.push_back(mk_req(FUNC_PIXEL, 8'h9A, 1'b1, 8'h12, 1'b0));
    // centre weight halved mid-image: interior pixel 0x33 lands on a rounding tie
    script.push_back(mk_reg(REG_COEF_MID, 48'h0000_0080_0000));
    script.push_back(mk_req(FUNC_PIXEL, 8'hBC, 1'b1, 8'h34, 1'b0));
    script.push_back(mk_req(FUNC_PIXEL, 8'hDE, 1'b0, 8'h00, 1'b0));
    script.push_back(mk_req(FUNC_FLUSH, 8'h00, 1'b1, 8'h78, 1'b0));
    script.push_back(mk_req(FUNC_FLUSH, 8'h00, 1'b1, 8'h9A, 1'b0));
    script.push_back(mk_req(FUNC_FLUSH, 8'h00, 1'b1, 8'hBC, 1'b0));
    script.push_back(mk_req(FUNC_FLUSH, 8'h00, 1'b1, 8'hDE, 1'b1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].idx, script[i].data);
      else send_px(script[i].op, script[i].pix, script[i].chk, script[i].xpix, script[i].xlast);
    end
    // leave the typed-expectation path before anything else is predicted
    row_chk <= 1'b0;
    @(negedge clk);

    // widest image (over-range width clips to the maximum) at full rate;
    // afterwards every line store column holds written data
    write_reg(REG_IMAGE_WIDTH, 48'd2047);
    write_reg(REG_IMAGE_HEIGHT, 48'd3);
    write_reg(REG_ABS_MODE, 48'd0);
    write_reg(REG_COEF_TOP, draw_reg(REG_COEF_TOP));
    write_reg(REG_COEF_MID, draw_reg(REG_COEF_MID));
    write_reg(REG_COEF_BOTTOM, draw_reg(REG_COEF_BOTTOM));
    calm <= 1'b1;
    run_image(-1);
    calm <= 1'b0;

    // tallest image, width zero acting as one column
    write_reg(REG_IMAGE_WIDTH, 48'd0);
    write_reg(REG_IMAGE_HEIGHT, 48'd4095);
    run_image(-1);

    feed_mark = n_feed;
    while (n_feed < feed_mark + RAND_ITEMS) begin
      calm <= (n_feed - feed_mark >= 700 && n_feed - feed_mark < 1000);
      for (int r = 0; r <= REG_COEF_BOTTOM; r++)
        if ($urandom_range(2) == 0) write_reg(r, draw_reg(r));
      if ($urandom_range(7) == 0) run_image($urandom_range(eff_w() * eff_h()));
      else run_image(-1);
    end
    calm <= 1'b0;

    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    $display("Covered %0d requests and %0d results over %0d images with %0d register writes,",
             n_req, n_res, n_img, n_regw);
    $display("from 1x1 up to 1024 wide and 4095 high, with mid-image rewrites; %0d mismatches.",
             n_miss);
    if (n_miss == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
